/* src/k_stacks_shared_store_unit_assert.svh */
// Assertion macros shared by the k_stacks_shared_store_unit RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef K_STACKS_SHARED_STORE_UNIT_ASSERT_SVH
`define K_STACKS_SHARED_STORE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/kss_pkg.sv */
// Shared types and codes for the k_stacks_shared_store_unit.
// No dependencies; kss_ctrl, kss_datapath and the top level import this package.
package kss_pkg;

	localparam int DATA_W = 32;
	localparam int ID_W   = 3;

	typedef enum logic {
		ACT_PUSH = 1'b0,
		ACT_POP  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		action_t                  action;
		logic [ID_W-1:0]          stack_id;
		logic signed [DATA_W-1:0] push_value;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] popped_value;
	} result_t;

	// Controller to datapath.
	typedef struct packed {
		logic init_wr;
		logic take;
		logic rd_pop;
		logic exec_push;
		logic exec_pop;
		logic fail;
		logic put;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic    init_last;
		logic    push_ok;
		logic    pop_ok;
		action_t act;
		logic    out_free;
	} dp_sts_t;

endpackage

/* src/kss_stream_if.sv */
// Valid/ready stream interface used for the item and result channels.
// The payload type is given per instance, normally a kss_pkg struct.
interface kss_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/kss_ctrl.sv */
// Sequencing state machine of the k_stacks_shared_store_unit.
// Depends on kss_pkg and the assertion macro header.
`include "k_stacks_shared_store_unit_assert.svh"

module kss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  kss_pkg::dp_sts_t  sts,
	output kss_pkg::ctrl_cmd_t cmd
);
	import kss_pkg::*;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_RD1,
		S_RD2,
		S_PUT
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign item_ready = ready_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
			end
			S_IDLE: begin
				cmd.take = item_valid;
			end
			S_RD1: begin
				if (sts.act == ACT_PUSH) begin
					cmd.exec_push = sts.push_ok;
					cmd.fail      = !sts.push_ok;
				end else begin
					cmd.rd_pop = sts.pop_ok;
					cmd.fail   = !sts.pop_ok;
				end
			end
			S_RD2: begin
				cmd.exec_pop = 1'b1;
			end
			S_PUT: begin
				cmd.put = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ready_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (sts.init_last) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_RD1;
						ready_q <= 1'b0;
					end
				end
				S_RD1: begin
					if (sts.act == ACT_POP && sts.pop_ok) begin
						state_q <= S_RD2;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_RD2: begin
					state_q <= S_PUT;
				end
				S_PUT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= S_INIT;
					ready_q <= 1'b0;
				end
			endcase
		end
	end

	`KSS_ASSERT_NEXT(a_take_reads, cmd.take, state_q == S_RD1, "accepted item did not start")
	`KSS_ASSERT_NOW(a_one_action, 1'b1, $onehot0({cmd.exec_push, cmd.exec_pop, cmd.fail, cmd.rd_pop}), "more than one operation in a cycle")
	`KSS_ASSERT_NOW(a_rd2_order, state_q == S_RD2, $past(state_q) == S_RD1, "second read without first")
	`KSS_ASSERT_NEXT(a_pop_second, state_q == S_RD1 && sts.act == ACT_POP && sts.pop_ok, state_q == S_RD2, "valid pop skipped its slot read")

endmodule

/* src/kss_datapath.sv */
// Datapath of the k_stacks_shared_store_unit: slot data, link and top stores,
// free list head and the result register. Depends on kss_pkg.
module kss_datapath #(
	parameter int SLOT_COUNT  = 16,
	parameter int STACK_COUNT = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kss_pkg::ctrl_cmd_t  cmd,
	output kss_pkg::dp_sts_t    sts,
	input  kss_pkg::item_t      item_data,
	output logic                result_valid,
	input  logic                result_ready,
	output kss_pkg::result_t    result_data
);
	import kss_pkg::*;

	localparam int SLOT_W  = $clog2(SLOT_COUNT);
	localparam int STACK_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;

	typedef struct packed {
		logic              valid;
		logic [SLOT_W-1:0] idx;
	} ptr_t;

	logic signed [DATA_W-1:0] data_mem [SLOT_COUNT];
	ptr_t                     link_mem [SLOT_COUNT];
	logic [SLOT_W-1:0]        top_mem  [STACK_COUNT];
	logic [STACK_COUNT-1:0]   top_vld_q;

	action_t                  act_q;
	logic [ID_W-1:0]          sid_q;
	logic signed [DATA_W-1:0] val_q;
	ptr_t                     fh_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        top_rd_q;
	ptr_t                     link_rd_q;
	logic signed [DATA_W-1:0] data_rd_q;
	logic [SLOT_W-1:0]        init_cnt_q;
	result_t                  res_q;
	logic                     out_valid_q;
	result_t                  out_q;

	logic [STACK_W-1:0] sid_idx;
	logic               sid_ok;
	logic [31:0]        init_nxt;
	logic [SLOT_W-1:0]  link_raddr;
	logic               link_we;
	logic [SLOT_W-1:0]  link_waddr;
	ptr_t               link_wdata;
	logic               out_free;

	assign sid_idx  = STACK_W'(sid_q);
	assign sid_ok   = 32'(sid_q) < 32'(STACK_COUNT);
	assign init_nxt = 32'(init_cnt_q) + 32'd1;
	assign out_free = !out_valid_q || result_ready;

	assign sts.init_last = init_cnt_q == SLOT_W'(SLOT_COUNT - 1);
	assign sts.push_ok   = sid_ok && fh_q.valid;
	assign sts.pop_ok    = sid_ok && top_vld_q[sid_idx];
	assign sts.act       = act_q;
	assign sts.out_free  = out_free;

	assign result_valid = out_valid_q;
	assign result_data  = out_q;

	// The link store has one write port, shared by the init sweep, push and pop.
	assign link_raddr = cmd.rd_pop ? top_rd_q : fh_q.idx;
	always_comb begin
		link_we    = 1'b0;
		link_waddr = fh_q.idx;
		link_wdata = fh_q;
		priority if (cmd.init_wr) begin
			link_we    = 1'b1;
			link_waddr = init_cnt_q;
			link_wdata = '{valid: init_nxt < 32'(SLOT_COUNT), idx: SLOT_W'(init_nxt)};
		end else if (cmd.exec_push) begin
			link_we    = 1'b1;
			link_waddr = fh_q.idx;
			link_wdata = '{valid: top_vld_q[sid_idx], idx: top_rd_q};
		end else if (cmd.exec_pop) begin
			link_we    = 1'b1;
			link_waddr = slot_q;
			link_wdata = fh_q;
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		link_rd_q <= link_mem[link_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_push) begin
			data_mem[fh_q.idx] <= val_q;
		end
		data_rd_q <= data_mem[top_rd_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.exec_push) begin
			top_mem[sid_idx] <= fh_q.idx;
		end else if (cmd.exec_pop) begin
			top_mem[sid_idx] <= link_rd_q.idx;
		end
		top_rd_q <= top_mem[STACK_W'(item_data.stack_id)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_vld_q   <= '0;
			fh_q        <= '{valid: 1'b1, idx: '0};
			init_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec_push) begin
				top_vld_q[sid_idx] <= 1'b1;
				fh_q               <= link_rd_q;
			end else if (cmd.exec_pop) begin
				top_vld_q[sid_idx] <= link_rd_q.valid;
				fh_q               <= '{valid: 1'b1, idx: slot_q};
			end
			if (cmd.init_wr) begin
				init_cnt_q <= SLOT_W'(init_nxt);
			end
			if (cmd.put) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			act_q <= item_data.action;
			sid_q <= item_data.stack_id;
			val_q <= item_data.push_value;
		end
		if (cmd.rd_pop) begin
			slot_q <= top_rd_q;
		end
		if (cmd.exec_push) begin
			res_q <= '{status: ST_DONE, popped_value: '0};
		end else if (cmd.exec_pop) begin
			res_q <= '{status: ST_DONE, popped_value: data_rd_q};
		end else if (cmd.fail) begin
			res_q <= '{status: (act_q == ACT_PUSH) ? ST_OVERFLOW : ST_UNDERFLOW,
				popped_value: '0};
		end
		if (cmd.put) begin
			out_q <= res_q;
		end
	end

endmodule

/* src/k_stacks_shared_store_unit.sv */
// Top level of the k_stacks_shared_store_unit: controller plus datapath.
// Depends on kss_pkg, kss_stream_if, kss_ctrl and kss_datapath.
//
// Usage: STACK_COUNT stacks share SLOT_COUNT slots. Each transfer on the item
// channel carries an action (push or pop), a stack_id and a push_value. Each
// item yields exactly one transfer on the result channel with a status (done,
// overflow, underflow) and popped_value, which is the removed value on a
// successful pop and zero otherwise. A push to a full store or a pop from an
// empty stack changes nothing; so does any stack_id at or above STACK_COUNT.
// Timing: one item is in work at a time. Item ready rises again when the item's
// result enters the output register; a push or a failed operation passes the
// states S_RD1 and S_PUT, a successful pop S_RD1, S_RD2 and S_PUT. Each step
// waits on a registered read of the link, top or data store, and the link
// store has a single read port. S_PUT moves the result into the output
// register and sets result valid. The result sits in an output register, so a
// stalled receiver holds only that item; the next item is accepted and worked
// up to the output register, where it waits until the previous result is taken.
// Reset: arst_n clears all stacks and sets the free list head to slot 0. The
// link store is then initialized by a sweep over all SLOT_COUNT slots, one
// slot per cycle, during which item ready stays low.
module k_stacks_shared_store_unit #(
	parameter int SLOT_COUNT  = 16,
	parameter int STACK_COUNT = 8
) (
	input logic          clk,
	input logic          arst_n,
	kss_stream_if.sink   item,
	kss_stream_if.source result
);
	import kss_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	// The controller owns the item handshake; the datapath owns the result side.
	kss_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	kss_datapath #(
		.SLOT_COUNT  (SLOT_COUNT),
		.STACK_COUNT (STACK_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_data    (item.data),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.result_data  (result.data)
	);

endmodule
